@@ src/spd_pkg.sv @@
// Shared types and constants for the serial packet deframer.
package spd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 4'd1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hA5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h5A;

  // The checksum byte must equal this value minus the payload sum.
  localparam logic [BYTE_W-1:0] CSUM_BASE = 8'hFF;

  typedef enum logic [5:0] {
    PH_HUNT1 = 6'b000001,
    PH_HUNT2 = 6'b000010,
    PH_CMD   = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_CSUM  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] command_id;
    logic [BYTE_W-1:0] payload_length;
    logic [BYTE_W-1:0] payload_index;
    logic [BYTE_W-1:0] payload_byte;
    logic              packet_end;
    logic              checksum_good;
  } res_t;

endpackage

@@ src/spd_ifs.sv @@
// Channel interfaces for the deframer: input words, result words and register writes.
interface spd_in_if;
  logic                      valid;
  logic                      ready;
  logic [spd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spd_out_if;
  logic                      valid;
  logic                      ready;
  logic [spd_pkg::BYTE_W-1:0] command_id;
  logic [spd_pkg::BYTE_W-1:0] payload_length;
  logic [spd_pkg::BYTE_W-1:0] payload_index;
  logic [spd_pkg::BYTE_W-1:0] payload_byte;
  logic                      packet_end;
  logic                      checksum_good;

  modport source (output valid, output command_id, output payload_length,
                  output payload_index, output payload_byte, output packet_end,
                  output checksum_good, input ready);
  modport sink   (input valid, input command_id, input payload_length,
                  input payload_index, input payload_byte, input packet_end,
                  input checksum_good, output ready);
endinterface

interface spd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [spd_pkg::CFG_IDX_W-1:0] index;
  logic [spd_pkg::BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/spd_cfg_regs.sv @@
// Sync byte configuration registers with their write decoder.
module spd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [spd_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [spd_pkg::BYTE_W-1:0]    wr_data,
  output spd_pkg::cfg_t                 cfg
);

  spd_pkg::cfg_t cfg_r;
  spd_pkg::cfg_t cfg_nxt;

  // Writes to indexes beyond the register list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        spd_pkg::REG_SYNC_FIRST:  cfg_nxt.sync_first  = wr_data;
        spd_pkg::REG_SYNC_SECOND: cfg_nxt.sync_second = wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= spd_pkg::SYNC_FIRST_RST;
      cfg_r.sync_second <= spd_pkg::SYNC_SECOND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/spd_parser.sv @@
// Framing state machine: header capture, payload counting and checksum check.
module spd_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [spd_pkg::BYTE_W-1:0] rx_byte,
  input  spd_pkg::cfg_t              cfg,
  output logic                       res_valid,
  output spd_pkg::res_t              res
);

  spd_pkg::phase_t            phase_r, phase_nxt;
  logic [spd_pkg::BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [spd_pkg::BYTE_W-1:0] len_r, len_nxt;
  logic [spd_pkg::BYTE_W-1:0] taken_r, taken_nxt;
  logic [spd_pkg::BYTE_W-1:0] sum_r, sum_nxt;
  logic [spd_pkg::BYTE_W-1:0] taken_inc;
  logic [spd_pkg::BYTE_W-1:0] expected;

  assign taken_inc = taken_r + 8'd1;
  assign expected  = spd_pkg::CSUM_BASE - sum_r;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    taken_nxt = taken_r;
    sum_nxt   = sum_r;
    res_valid = 1'b0;
    res.command_id     = cmd_r;
    res.payload_length = len_r;
    res.payload_index  = taken_r;
    res.payload_byte   = rx_byte;
    res.packet_end     = 1'b0;
    res.checksum_good  = 1'b0;
    unique case (phase_r)
      spd_pkg::PH_HUNT2: begin
        // The second sync byte wins when both sync values are equal.
        if (rx_byte == cfg.sync_second) begin
          phase_nxt = spd_pkg::PH_CMD;
        end else if (rx_byte == cfg.sync_first) begin
          phase_nxt = spd_pkg::PH_HUNT2;
        end else begin
          phase_nxt = spd_pkg::PH_HUNT1;
        end
      end
      spd_pkg::PH_CMD: begin
        cmd_nxt   = rx_byte;
        phase_nxt = spd_pkg::PH_LEN;
      end
      spd_pkg::PH_LEN: begin
        len_nxt   = rx_byte;
        taken_nxt = '0;
        sum_nxt   = '0;
        phase_nxt = (rx_byte == '0) ? spd_pkg::PH_CSUM : spd_pkg::PH_DATA;
      end
      spd_pkg::PH_DATA: begin
        res_valid = 1'b1;
        sum_nxt   = sum_r + rx_byte;
        taken_nxt = taken_inc;
        if (taken_inc == len_r) begin
          phase_nxt = spd_pkg::PH_CSUM;
        end
      end
      spd_pkg::PH_CSUM: begin
        res_valid          = 1'b1;
        res.payload_index  = '0;
        res.payload_byte   = '0;
        res.packet_end     = 1'b1;
        res.checksum_good  = (rx_byte == expected);
        phase_nxt          = spd_pkg::PH_HUNT1;
      end
      default: begin
        // Hunting for the first sync byte; any stray code lands here too.
        cmd_nxt   = '0;
        len_nxt   = '0;
        taken_nxt = '0;
        sum_nxt   = '0;
        phase_nxt = (rx_byte == cfg.sync_first) ? spd_pkg::PH_HUNT2 : spd_pkg::PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= spd_pkg::PH_HUNT1;
      cmd_r   <= '0;
      len_r   <= '0;
      taken_r <= '0;
      sum_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      taken_r <= taken_nxt;
      sum_r   <= sum_nxt;
    end
  end

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("parser phase register lost its one-hot code");

  a_zero_len_to_csum: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (phase_r == spd_pkg::PH_LEN) && (rx_byte == '0)
    |=> phase_r == spd_pkg::PH_CSUM)
    else $error("zero-length packet did not go straight to the checksum word");

  a_csum_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (phase_r == spd_pkg::PH_CSUM) |=> phase_r == spd_pkg::PH_HUNT1)
    else $error("parser did not return to sync hunt after the checksum word");

endmodule

@@ src/spd_out_stage.sv @@
// Result register that holds one finished word until the receiver takes it.
module spd_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  spd_pkg::res_t load_item,
  input  logic          out_ready,
  output logic          out_valid,
  output spd_pkg::res_t out_item,
  output logic          can_take
);

  logic          valid_r, valid_nxt;
  spd_pkg::res_t item_r;

  // A new word may enter when the register is empty or drains this cycle.
  assign can_take = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(load && valid_r && !out_ready))
    else $error("result word overwritten before the receiver took it");

endmodule

@@ src/serial_packet_deframer_core.sv @@
// Top level of the serial packet deframer: channels, config registers and result path.
//
// Usage: feed one received serial byte per word on in_ch. The block hunts for
// the two sync bytes held in configuration registers 0 and 1, then takes a
// command byte, a length byte and that many payload bytes, and finally a
// checksum byte. Each payload byte comes out on out_ch as one word carrying
// the command, the declared length and the byte's index. The checksum byte
// produces one end word with packet_end set and checksum_good telling whether
// it equaled 0xFF minus the low byte of the payload sum. Sync, command and
// length bytes produce no word.
// Throughput is one input word per cycle unless out_ch stalls. A result word
// appears on out_ch in the cycle after its input word is accepted, held in
// the single result register. When the receiver stalls, the result holds in
// place and in_ch.ready drops until the word is taken, so nothing is lost.
// The cfg_ch port accepts a write every cycle; writes to unknown indexes are
// ignored. Synchronous reset restores the default sync bytes (0xA5, 0x5A),
// returns the parser to the sync hunt and empties the result register.
module serial_packet_deframer_core (
  input logic         clk,
  input logic         rst_n,
  spd_in_if.sink      in_ch,
  spd_out_if.source   out_ch,
  spd_cfg_if.sink     cfg_ch
);

  spd_pkg::cfg_t cfg;
  spd_pkg::res_t res;
  spd_pkg::res_t out_item;
  logic          res_valid;
  logic          in_accept;
  logic          can_take;

  // Register writes are always taken at once.
  assign cfg_ch.ready = 1'b1;

  spd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // An input word is taken whenever the result register has room, whether or
  // not this particular byte yields a result.
  assign in_ch.ready = can_take;
  assign in_accept   = in_ch.valid && can_take;

  spd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .rx_byte   (in_ch.rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  spd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept && res_valid),
    .load_item (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_item  (out_item),
    .can_take  (can_take)
  );

  assign out_ch.command_id     = out_item.command_id;
  assign out_ch.payload_length = out_item.payload_length;
  assign out_ch.payload_index  = out_item.payload_index;
  assign out_ch.payload_byte   = out_item.payload_byte;
  assign out_ch.packet_end     = out_item.packet_end;
  assign out_ch.checksum_good  = out_item.checksum_good;

  a_end_word_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.packet_end |-> out_ch.payload_byte == '0)
    else $error("end word carries a nonzero payload byte");

endmodule
